### design/rta_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the character ramp for the RGB to ASCII art stream.
package rta_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;   // config register width
    localparam int CNT_W         = 12;   // column / row counter width
    localparam int COLOR_W       = 8;
    localparam int CHAR_W        = 7;
    localparam int SUM_W         = 18;   // 1000 * luma, at most 255000
    localparam int LEVEL_W       = 5;

    // Config register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = DIM_W'(480);

    // Luma weights over a scale of 1000
    localparam logic [SUM_W-1:0] WEIGHT_RED   = SUM_W'(299);
    localparam logic [SUM_W-1:0] WEIGHT_GREEN = SUM_W'(587);
    localparam logic [SUM_W-1:0] WEIGHT_BLUE  = SUM_W'(114);

    // level = floor(sum / 8000) = floor((sum >> 6) / 125);
    // x / 125 as (x * 8389) >> 20, exact for x < 4096.
    localparam int SHIFT_PRE  = 6;
    localparam int RECIP_SH   = 20;
    localparam int TRUNC_W    = SUM_W - SHIFT_PRE;       // 12
    localparam int PROD_W     = RECIP_SH + LEVEL_W;      // 25
    localparam logic [PROD_W-1:0] RECIP_125 = PROD_W'(8389);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Queue entry: one classified pixel
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              newline;
    } qentry_t;

    // Dark to light ramp
    function automatic logic [CHAR_W-1:0] ramp_char(input logic [LEVEL_W-1:0] level);
        logic [CHAR_W-1:0] c;
        unique case (level)
            5'd0:  c = 7'd64;   // @
            5'd1:  c = 7'd66;   // B
            5'd2:  c = 7'd37;   // %
            5'd3:  c = 7'd56;   // 8
            5'd4:  c = 7'd38;   // &
            5'd5:  c = 7'd87;   // W
            5'd6:  c = 7'd77;   // M
            5'd7:  c = 7'd90;   // Z
            5'd8:  c = 7'd79;   // O
            5'd9:  c = 7'd85;   // U
            5'd10: c = 7'd89;   // Y
            5'd11: c = 7'd88;   // X
            5'd12: c = 7'd120;  // x
            5'd13: c = 7'd114;  // r
            5'd14: c = 7'd49;   // 1
            5'd15: c = 7'd123;  // {
            5'd16: c = 7'd125;  // }
            5'd17: c = 7'd91;   // [
            5'd18: c = 7'd93;   // ]
            5'd19: c = 7'd63;   // ?
            5'd20: c = 7'd45;   // -
            5'd21: c = 7'd95;   // _
            5'd22: c = 7'd43;   // +
            5'd23: c = 7'd126;  // ~
            5'd24: c = 7'd60;   // <
            5'd25: c = 7'd62;   // >
            5'd26: c = 7'd33;   // !
            5'd27: c = 7'd59;   // ;
            5'd28: c = 7'd58;   // :
            5'd29: c = 7'd44;   // ,
            5'd30: c = 7'd46;   // .
            5'd31: c = 7'd96;   // `
            default: c = 7'd64;
        endcase
        return c;
    endfunction

    // Zero acts as one, oversized acts as the maximum
    function automatic logic [DIM_W-1:0] effective_size(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] e;
        if (dim == '0)
            e = DIM_W'(1);
        else if (dim > DIM_W'(MAX_DIMENSION))
            e = DIM_W'(MAX_DIMENSION);
        else
            e = dim;
        return e;
    endfunction

endpackage

### design/rta_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for pixel words and character words.
interface rta_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rta_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last_of_run;

    modport source (output valid, output character, output last_of_run, input ready);
    modport sink   (input valid, input character, input last_of_run, output ready);
endinterface

### design/rta_front.sv
`timescale 1ns / 1ps
// Front end: config registers, raster counters, luma sum and character classification.
module rta_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [rta_pkg::DIM_W-1:0] cfg_data,
    rta_pixel_if.sink                 pixels,
    output logic                      push_valid,
    output rta_pkg::qentry_t          push_entry,
    input  logic                      push_ready
);
    import rta_pkg::*;

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [SUM_W-1:0]  s1_sum_reg, s1_sum_next;
    logic              s1_nl_reg, s1_nl_next;

    logic              accept;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [DIM_W-1:0]  col_inc, row_inc;
    logic [TRUNC_W-1:0] sum_trunc;
    logic [PROD_W-1:0] prod;
    logic [LEVEL_W-1:0] level;

    assign pixels.ready = !s1_valid_reg || push_ready;
    assign accept       = pixels.valid && pixels.ready;

    // config writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
        end
    end

    // raster position; wrap test is counter + 1 >= size
    always_comb
    begin
        w_eff    = effective_size(width_reg);
        h_eff    = effective_size(height_reg);
        col_inc  = {1'b0, col_reg} + DIM_W'(1);
        row_inc  = {1'b0, row_reg} + DIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    // stage 1: weighted sum and newline flag
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (push_ready)
            s1_valid_next = 1'b0;
        s1_sum_next = SUM_W'(pixels.red)   * WEIGHT_RED
                    + SUM_W'(pixels.green) * WEIGHT_GREEN
                    + SUM_W'(pixels.blue)  * WEIGHT_BLUE;
        s1_nl_next  = (col_reg == '0) && (row_reg != '0);
    end

    // stage 2: level = sum / 8000 by reciprocal, then ramp lookup
    always_comb
    begin
        sum_trunc             = s1_sum_reg[SUM_W-1:SHIFT_PRE];
        prod                  = PROD_W'(sum_trunc) * RECIP_125;
        level                 = prod[PROD_W-1:RECIP_SH];
        push_valid            = s1_valid_reg;
        push_entry.character  = ramp_char(level);
        push_entry.newline    = s1_nl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= IMAGE_WIDTH_RESET;
            height_reg   <= IMAGE_HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg <= s1_sum_next;
            s1_nl_reg  <= s1_nl_next;
        end
    end

endmodule

### design/rta_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified pixels between front and back end.
module rta_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  rta_pkg::qentry_t push_entry,
    output logic             push_ready,
    output logic             head_valid,
    output rta_pkg::qentry_t head_entry,
    input  logic             pop
);
    import rta_pkg::*;

    qentry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### design/rta_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued pixel into its character words behind an output register.
module rta_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  rta_pkg::qentry_t head_entry,
    output logic             pop,
    rta_char_if.source       chars
);
    import rta_pkg::*;

    logic [1:0]        phase_reg, phase_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              load, last;

    assign chars.valid       = out_valid_reg;
    assign chars.character   = out_char_reg;
    assign chars.last_of_run = out_last_reg;

    always_comb
    begin
        load = head_valid && (!out_valid_reg || chars.ready);
        // words: [newline,] char, char(last)
        last = head_entry.newline ? (phase_reg == 2'd2) : (phase_reg == 2'd1);
        pop  = load && last;

        out_char_next = (head_entry.newline && (phase_reg == 2'd0))
                      ? NEWLINE_CODE : head_entry.character;
        out_last_next = last;

        phase_next = phase_reg;
        if (load)
            phase_next = last ? 2'd0 : phase_reg + 2'd1;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (chars.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= out_char_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

### design/rgb_to_ascii_art_stream.sv
`timescale 1ns / 1ps
// A pixel word is held in front stage 1, then in the queue, then in the output register.
// Throughput: 2 character words per pixel, 3 on the first pixel of each row after the first;
//   the output register sends one word per cycle when not stalled, setting the pixel rate.
// The front takes a new pixel every cycle while the 4-entry queue has room.
// Reset (async, active low): counters cleared, image 640 x 480, queue and output empty.
module rgb_to_ascii_art_stream (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [rta_pkg::DIM_W-1:0] cfg_data,
    rta_pixel_if.sink                 pixels,
    rta_char_if.source                chars
);
    import rta_pkg::*;

    // front -> queue
    logic    push_valid;
    logic    push_ready;
    qentry_t push_entry;

    // queue -> back
    logic    head_valid;
    logic    pop;
    qentry_t head_entry;

    // Front: config, raster counters, luma and ramp lookup (2 stages)
    rta_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixels     (pixels),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // Decouples front from the slower word expansion
    rta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // Back: optional newline plus doubled character, one word per cycle while the receiver is ready
    rta_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .chars      (chars)
    );

endmodule

### tb/rta_art_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB to ASCII art stream: predicts character words and compares them.
module rta_art_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [rta_pkg::DIM_W-1:0] cfg_data,
    rta_pixel_if                      pixels,
    rta_char_if                       chars,
    output int                        errors,
    output int                        pending
);

    // Dark to light glyphs, first character in the top byte; \140 is the backquote
    localparam logic [32*8-1:0] GLYPHS = "@B%8&WMZOUYXxr1{}[]?-_+~<>!;:,.\140";

    typedef struct packed {
        logic [rta_pkg::CHAR_W-1:0] character;
        logic                       last_of_run;
    } art_char_t;

    art_char_t                 expected_chars [$];
    logic [rta_pkg::DIM_W-1:0] width_reg;
    logic [rta_pkg::DIM_W-1:0] height_reg;
    int unsigned               column_pos;
    int unsigned               row_pos;

    function automatic int unsigned dim_in_use(input logic [rta_pkg::DIM_W-1:0] d);
        if (d == '0)
            return 1;
        if (d > rta_pkg::MAX_DIMENSION)
            return rta_pkg::MAX_DIMENSION;
        return 32'(d);
    endfunction

    function automatic logic [rta_pkg::CHAR_W-1:0] glyph_for(input logic [7:0] r,
                                                             input logic [7:0] g,
                                                             input logic [7:0] b);
        int unsigned luma;
        int unsigned level;
        luma  = (299 * r + 587 * g + 114 * b) / 1000;
        level = luma / 8;
        // low 7 bits of the byte for this level
        return GLYPHS[8 * (31 - level) +: 7];
    endfunction

    task automatic push_char(input logic [rta_pkg::CHAR_W-1:0] c, input logic last);
        art_char_t w;
        w.character   = c;
        w.last_of_run = last;
        expected_chars.push_back(w);
    endtask

    task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        logic [rta_pkg::CHAR_W-1:0] c;
        c = glyph_for(r, g, b);
        // newline opens every row but the first one of an image
        if (column_pos == 0 && row_pos != 0)
            push_char(rta_pkg::NEWLINE_CODE, 1'b0);
        push_char(c, 1'b0);
        push_char(c, 1'b1);
        if (column_pos + 1 >= dim_in_use(width_reg))
        begin
            column_pos = 0;
            if (row_pos + 1 >= dim_in_use(height_reg))
                row_pos = 0;
            else
                row_pos = row_pos + 1;
        end
        else
        begin
            column_pos = column_pos + 1;
        end
    endtask

    task automatic check_char(input logic [rta_pkg::CHAR_W-1:0] c, input logic last);
        art_char_t want;
        if (expected_chars.size() == 0)
        begin
            errors = errors + 1;
            if (errors <= 10)
                $display("%0t: unexpected character word %0d last %0b", $time, c, last);
        end
        else
        begin
            want = expected_chars.pop_front();
            if (want.character !== c || want.last_of_run !== last)
            begin
                errors = errors + 1;
                if (errors <= 10)
                    $display({"%0t: character word mismatch: expected %0d last %0b,",
                              " got %0d last %0b"},
                             $time, want.character, want.last_of_run, c, last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
            width_reg  = rta_pkg::IMAGE_WIDTH_RESET;
            height_reg = rta_pkg::IMAGE_HEIGHT_RESET;
            column_pos = 0;
            row_pos    = 0;
            errors     = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rta_pkg::CFG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (pixels.valid && pixels.ready)
                predict_pixel(pixels.red, pixels.green, pixels.blue);
            if (chars.valid && chars.ready)
                check_char(chars.character, chars.last_of_run);
            pending <= expected_chars.size();
        end
    end

endmodule

### tb/rgb_to_ascii_art_stream_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives pixel words and image sizes, paces the receiver, gives the verdict.
module rgb_to_ascii_art_stream_tb;

    // The watchdog ends the run if no word is accepted on either side for this many cycles.
    // The longest legal quiet stretch comes from the forced receiver hold.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASES         = 9;
    localparam int PHASE_PIXELS   = 40;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [rta_pkg::DIM_W-1:0] cfg_data;
    int                        errors;
    int                        pending_words;

    // Pacing knobs in percent, per pixel word or receiver draw; zero gives no idling
    int tx_gap_pct;
    int rx_stall_pct;
    bit long_hold_req;

    rta_pixel_if pixel_bus ();
    rta_char_if  char_bus ();

    rgb_to_ascii_art_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixel_bus),
        .chars     (char_bus)
    );

    rta_art_checker art_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixel_bus),
        .chars     (char_bus),
        .errors    (errors),
        .pending   (pending_words)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Image sizes: the extremes (zero, one, the maximum, all ones) show up often,
    // small sizes dominate so that newlines and image wraps happen a lot.
    function automatic logic [rta_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return rta_pkg::DIM_W'(1);
            2:       return rta_pkg::DIM_W'(rta_pkg::MAX_DIMENSION);
            3:       return '1;
            4:       return rta_pkg::DIM_W'($urandom_range(0, 8191));
            default: return rta_pkg::DIM_W'($urandom_range(2, 9));
        endcase
    endfunction

    // Mix of random colors, grays sitting right on a level boundary, and saturated colors
    task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
        logic [7:0] v;
        case ($urandom_range(0, 3))
            2:
            begin
                v = 8'(8 * $urandom_range(1, 31) - $urandom_range(0, 1));
                r = v;
                g = v;
                b = v;
            end
            3:
            begin
                r = $urandom_range(0, 1) ? 8'hff : 8'h00;
                g = $urandom_range(0, 1) ? 8'hff : 8'h00;
                b = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            default:
            begin
                r = 8'($urandom_range(0, 255));
                g = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
            end
        endcase
    endtask

    // Offer one pixel word and hold it until accepted. valid stays high into the
    // next word unless a gap is drawn.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_bus.valid <= 1'b1;
        pixel_bus.red   <= r;
        pixel_bus.green <= g;
        pixel_bus.blue  <= b;
        @(posedge clk);
        while (!pixel_bus.ready)
            @(posedge clk);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            pixel_bus.valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every predicted character word. Each pixel makes
    // at least two words, so the block is idle once the count drops to zero.
    task automatic settle();
        pixel_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
    endtask

    // Write both size registers; only called with the block idle
    task automatic configure(input logic [rta_pkg::DIM_W-1:0] w,
                             input logic [rta_pkg::DIM_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= rta_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= rta_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: random stalls, plus one forced long hold so the block's queue fills
    // and back-pressure reaches the pixel side.
    initial
    begin : char_receiver
        int stall_left;
        bit hold_done;
        stall_left     = 0;
        hold_done      = 1'b0;
        char_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_done)
            begin
                char_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                char_bus.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                char_bus.ready <= 1'b0;
                stall_left = gap_len() - 1;
            end
            else
            begin
                char_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run after too long without any accepted word
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_bus.valid && pixel_bus.ready) || (char_bus.valid && char_bus.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("rgb_to_ascii_art_stream_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         phase;
        int         n;

        // Everything known from time zero
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = rta_pkg::CFG_IMAGE_WIDTH;
        cfg_data        = '0;
        pixel_bus.valid = 1'b0;
        pixel_bus.red   = '0;
        pixel_bus.green = '0;
        pixel_bus.blue  = '0;
        tx_gap_pct      = 20;
        rx_stall_pct    = 20;
        long_hold_req   = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset size 640 x 480, color extremes and exact level boundaries.
        // A gray has luma equal to its value, so 7/8 and 247/248 straddle levels.
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hff, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hff);
        send_pixel(8'd7, 8'd7, 8'd7);
        send_pixel(8'd8, 8'd8, 8'd8);
        send_pixel(8'd248, 8'd248, 8'd248);
        settle();

        // Zero width acts as one, oversized height as the maximum; the column
        // counter sits past the new width, so it wraps on the next pixel.
        configure('0, '1);
        send_pixel(8'd247, 8'd247, 8'd247);
        send_pixel(8'h80, 8'h40, 8'h20);
        send_pixel(8'h01, 8'hfe, 8'h7f);
        settle();

        // Oversized width, zero height: one endless row, a newline only on its first pixel
        configure('1, '0);
        send_pixel(8'hfe, 8'hfd, 8'hfb);
        send_pixel(8'h10, 8'h20, 8'h30);
        settle();

        // 3 x 2 image: one newline, then the image end returns to the top left
        configure(rta_pkg::DIM_W'(3), rta_pkg::DIM_W'(2));
        for (n = 0; n < 7; n++)
        begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        settle();

        // Width shrinks mid-row: counter already past the new width wraps at once
        configure(rta_pkg::DIM_W'(5), rta_pkg::DIM_W'(4));
        for (n = 0; n < 4; n++)
        begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        settle();
        configure(rta_pkg::DIM_W'(2), rta_pkg::DIM_W'(4));
        for (n = 0; n < 3; n++)
        begin
            pick_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        settle();

        // Random phases, each with its own image size and pacing
        for (phase = 0; phase < PHASES; phase++)
        begin
            configure(pick_dim(), pick_dim());
            if (phase % 3 == 0)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                tx_gap_pct   = $urandom_range(5, 50);
                rx_stall_pct = $urandom_range(5, 50);
            end
            // Receiver holds off while the sender keeps pushing back to back
            if (phase == 1)
            begin
                tx_gap_pct    = 0;
                long_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_PIXELS; n++)
            begin
                pick_pixel(r, g, b);
                send_pixel(r, g, b);
                // Sender pauses mid-image until the output side has drained
                if (phase == 4 && n == PHASE_PIXELS / 2)
                    settle();
            end
            settle();
        end

        // Drained; keep clocking to catch any stray word before the verdict
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("rgb_to_ascii_art_stream_tb: done, clean");
        else
            $display("rgb_to_ascii_art_stream_tb: done, errors");
        $finish;
    end

endmodule
